FILE: sv/sha1he_pkg.sv
// SHA-1 hash engine: shared types, constants and round functions.
// No dependencies; imported by sha1_hash_engine_unit.
package sha1he_pkg;

    localparam int unsigned NUM_CHAIN   = 5;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS  = 80;

    localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
        32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
    };

    localparam logic [31:0] K_ROUND0 = 32'h5a82_7999;
    localparam logic [31:0] K_ROUND1 = 32'h6ed9_eba1;
    localparam logic [31:0] K_ROUND2 = 32'h8f1b_bcdc;
    localparam logic [31:0] K_ROUND3 = 32'hca62_c1d6;

    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [6:0]  LAST_ROUND  = 7'(NUM_ROUNDS - 1);
    localparam logic [3:0]  LEN_HI_SLOT = 4'(BLOCK_WORDS - 2);
    localparam logic [3:0]  LEN_LO_SLOT = 4'(BLOCK_WORDS - 1);
    localparam logic [2:0]  LAST_INDEX  = 3'(NUM_CHAIN - 1);
    localparam logic [2:0]  FULL_BYTES  = 3'd4;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_result;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } eng_state_t;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)      k = K_ROUND0;
        else if (t < 7'd40) k = K_ROUND1;
        else if (t < 7'd60) k = K_ROUND2;
        else                k = K_ROUND3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)      f = (b & c) | (~b & d);
        else if (t < 7'd40) f = b ^ c ^ d;
        else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction

endpackage

FILE: sv/sha1_hash_engine_unit.sv
// SHA-1 hash engine top level: word intake, padding, one-round-per-cycle compression.
// Depends on sha1he_pkg.
//
//  channel | ports                      | carries
//  --------+----------------------------+-------------------------------------------
//  input   | s_valid, s_ready, s_data   | message word, valid byte count, last flag
//  output  | m_valid, m_ready, m_data   | digest word, word index, last flag
//
// A message word is taken on each s_valid/s_ready handshake. Every 16th word (message
// or pad) starts the compression: the rounds on the single round adder, then the
// chaining add. After the last word the pad words go in at one per cycle, with one or
// two compressions, then the five digest words leave one per accepted handshake.
// s_ready is low while a block compresses, during padding and during digest output.
// Reset is synchronous on aresetn.
module sha1_hash_engine_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha1he_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha1he_pkg::out_word_t m_data
);
    import sha1he_pkg::*;

    eng_state_t  state_reg, state_next;

    logic [31:0] chain_reg [NUM_CHAIN];
    logic [31:0] work_reg  [NUM_CHAIN];
    logic [31:0] sched_reg [BLOCK_WORDS];
    logic [63:0] msg_bits_reg;
    logic [3:0]  slot_reg;
    logic [6:0]  round_reg;
    logic [2:0]  out_idx_reg;
    logic        pad_mode_reg;    // message ended, padding in progress
    logic        pad80_reg;       // full last word: separate pad word still owed
    logic        hi_done_reg;     // upper length word is in the buffer
    logic        final_reg;       // lower length word pushed, last block underway

    logic        in_acc;
    logic        out_acc;
    logic        push_en;
    logic [31:0] push_word;
    logic [2:0]  v_sat;
    logic [31:0] last_mask;
    logic [31:0] last_pad;
    logic [31:0] last_word_val;
    logic [31:0] pad_word;
    logic        pad_is_hi;
    logic        pad_is_lo;
    logic [31:0] sched_x;
    logic [31:0] wt;
    logic [31:0] round_sum;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // last word: mask the unused bytes and place the pad byte right after the data
    always_comb begin
        v_sat = (s_data.valid_bytes > FULL_BYTES) ? FULL_BYTES : s_data.valid_bytes;
        case (v_sat)
            3'd0:    begin last_mask = 32'h0000_0000; last_pad = {PAD_BYTE, 24'h0};      end
            3'd1:    begin last_mask = 32'hff00_0000; last_pad = {8'h0, PAD_BYTE, 16'h0}; end
            3'd2:    begin last_mask = 32'hffff_0000; last_pad = {16'h0, PAD_BYTE, 8'h0}; end
            3'd3:    begin last_mask = 32'hffff_ff00; last_pad = {24'h0, PAD_BYTE};       end
            default: begin last_mask = 32'hffff_ffff; last_pad = 32'h0;                   end
        endcase
        last_word_val = (s_data.data_word & last_mask) | last_pad;
    end

    // padding sequence: owed pad word, zeros, then the 64-bit length in the last two slots
    always_comb begin
        pad_is_hi = 1'b0;
        pad_is_lo = 1'b0;
        if (pad80_reg) begin
            pad_word = {PAD_BYTE, 24'h0};
        end else if (slot_reg == LEN_HI_SLOT) begin
            pad_word  = msg_bits_reg[63:32];
            pad_is_hi = 1'b1;
        end else if (slot_reg == LEN_LO_SLOT && hi_done_reg) begin
            pad_word  = msg_bits_reg[31:0];
            pad_is_lo = 1'b1;
        end else begin
            pad_word = 32'h0;
        end
    end

    always_comb begin
        push_en   = 1'b0;
        push_word = pad_word;
        if (state_reg == ST_IDLE && in_acc) begin
            push_en   = 1'b1;
            push_word = s_data.last_word ? last_word_val : s_data.data_word;
        end else if (state_reg == ST_PAD) begin
            push_en = 1'b1;
        end
    end

    // round datapath; the schedule window sits at fixed taps of the shift line
    always_comb begin
        sched_x   = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        wt        = (round_reg < 7'(BLOCK_WORDS)) ? sched_reg[0] : {sched_x[30:0], sched_x[31]};
        round_sum = {work_reg[0][26:0], work_reg[0][31:27]}
                  + round_f(round_reg, work_reg[1], work_reg[2], work_reg[3])
                  + work_reg[4] + round_k(round_reg) + wt;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (slot_reg == LEN_LO_SLOT) state_next = ST_ROUND;
                    else if (s_data.last_word)   state_next = ST_PAD;
                end
            end
            ST_ROUND: begin
                if (round_reg == LAST_ROUND) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (final_reg)         state_next = ST_OUT;
                else if (pad_mode_reg) state_next = ST_PAD;
                else                   state_next = ST_IDLE;
            end
            ST_PAD: begin
                if (slot_reg == LEN_LO_SLOT) state_next = ST_ROUND;
            end
            ST_OUT: begin
                if (out_acc && out_idx_reg == LAST_INDEX) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready            = (state_reg == ST_IDLE);
        m_valid            = (state_reg == ST_OUT);
        m_data.digest_word = chain_reg[0];
        m_data.word_index  = out_idx_reg;
        m_data.last_result = (out_idx_reg == LAST_INDEX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            msg_bits_reg <= '0;
            slot_reg     <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            pad_mode_reg <= 1'b0;
            pad80_reg    <= 1'b0;
            hi_done_reg  <= 1'b0;
            final_reg    <= 1'b0;
            for (int i = 0; i < NUM_CHAIN; i++) begin
                chain_reg[i] <= H_INIT[i];
                work_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (in_acc) begin
                if (s_data.last_word) begin
                    msg_bits_reg <= msg_bits_reg + {58'h0, v_sat, 3'b000};
                    pad_mode_reg <= 1'b1;
                    pad80_reg    <= (v_sat == FULL_BYTES);
                end else begin
                    msg_bits_reg <= msg_bits_reg + 64'd32;
                end
            end

            if (state_reg == ST_PAD) begin
                pad80_reg <= 1'b0;
                if (pad_is_hi) hi_done_reg <= 1'b1;
                if (pad_is_lo) final_reg   <= 1'b1;
            end

            if (push_en) begin
                slot_reg <= slot_reg + 4'd1;
                if (slot_reg == LEN_LO_SLOT) begin
                    round_reg <= '0;
                    for (int i = 0; i < NUM_CHAIN; i++) work_reg[i] <= chain_reg[i];
                end
            end

            if (state_reg == ST_ROUND) begin
                round_reg   <= round_reg + 7'd1;
                work_reg[0] <= round_sum;
                work_reg[1] <= work_reg[0];
                work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
                work_reg[3] <= work_reg[2];
                work_reg[4] <= work_reg[3];
            end

            if (state_reg == ST_UPDATE) begin
                round_reg <= '0;
                for (int i = 0; i < NUM_CHAIN; i++) chain_reg[i] <= chain_reg[i] + work_reg[i];
                if (final_reg) begin
                    pad_mode_reg <= 1'b0;
                    hi_done_reg  <= 1'b0;
                    final_reg    <= 1'b0;
                    out_idx_reg  <= '0;
                end
            end

            // digest leaves from chain_reg[0]; init values rotate in behind it
            if (out_acc) begin
                for (int i = 0; i < NUM_CHAIN - 1; i++) chain_reg[i] <= chain_reg[i + 1];
                chain_reg[NUM_CHAIN - 1] <= H_INIT[out_idx_reg];
                out_idx_reg              <= out_idx_reg + 3'd1;
                if (out_idx_reg == LAST_INDEX) msg_bits_reg <= '0;
            end
        end
    end

    // block buffer as a shift line: pushes and rounds both enter at the top
    always_ff @(posedge aclk) begin
        if (push_en || state_reg == ST_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) sched_reg[i] <= sched_reg[i + 1];
            sched_reg[BLOCK_WORDS - 1] <= push_en ? push_word : wt;
        end
    end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for sha1_hash_engine_unit: streams messages in as 32-bit words
// and compares every digest word against an in-bench SHA-1 predictor.
// Depends on sha1he_pkg (port struct types) and the engine RTL.
module tb_top;
    import sha1he_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned RANDOM_WORDS  = 88;
    localparam int unsigned SETTLE_CYCLES = 250;

    // receiver stall patterns
    localparam int unsigned RX_ALWAYS   = 0;
    localparam int unsigned RX_COIN     = 1;
    localparam int unsigned RX_PERIODIC = 2;
    localparam int unsigned RX_SPARSE   = 3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // predictor state
    logic [31:0] hash_state [5];
    logic [31:0] block_buf [16];
    logic [63:0] bit_count;
    int unsigned buf_slot;
    out_word_t   digest_q [$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_mode  = RX_ALWAYS;
    int unsigned stall_timer = 0;

    sha1_hash_engine_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void restart_hash();
        hash_state[0] = 32'h6745_2301;
        hash_state[1] = 32'hefcd_ab89;
        hash_state[2] = 32'h98ba_dcfe;
        hash_state[3] = 32'h1032_5476;
        hash_state[4] = 32'hc3d2_e1f0;
        bit_count = '0;
        buf_slot  = 0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, x, sum;
        int t;
        for (t = 0; t < 16; t++) w[t] = block_buf[t];
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
        d = hash_state[3]; e = hash_state[4];
        for (t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                x = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
                wt = {x[30:0], x[31]};
                w[t % 16] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);         k = 32'h5a82_7999;
            end else if (t < 40) begin
                f = b ^ c ^ d;                  k = 32'h6ed9_eba1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8f1b_bcdc;
            end else begin
                f = b ^ c ^ d;                  k = 32'hca62_c1d6;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + wt;
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = sum;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
        hash_state[3] += d; hash_state[4] += e;
    endfunction

    function automatic void load_block_word(logic [31:0] w);
        block_buf[buf_slot] = w;
        buf_slot = (buf_slot + 1) % 16;
        if (buf_slot == 0) compress_block();
    endfunction

    // Called once per accepted word; queues the five digest words after a last word.
    function automatic void absorb_word(logic [31:0] data, logic [2:0] nbytes, logic fin);
        int unsigned nb;
        logic [31:0] w;
        out_word_t   dw;
        if (!fin) begin
            // byte count is ignored on a word that is not last
            bit_count += 64'd32;
            load_block_word(data);
            return;
        end
        nb = (nbytes > 3'd4) ? 4 : nbytes;
        bit_count += 64'(8 * nb);
        w = (nb == 0) ? 32'h0 : (data & (32'hffff_ffff << (32 - 8 * nb)));
        if (nb < 4) begin
            w |= 32'h80 << (24 - 8 * nb);
            load_block_word(w);
        end else begin
            load_block_word(w);
            load_block_word(32'h8000_0000);
        end
        while (buf_slot != 14) load_block_word(32'h0);
        load_block_word(bit_count[63:32]);
        load_block_word(bit_count[31:0]);
        for (int i = 0; i < 5; i++) begin
            dw.digest_word = hash_state[i];
            dw.word_index  = 3'(i);
            dw.last_result = (i == 4);
            digest_q.push_back(dw);
        end
        restart_hash();
    endfunction

    // ---------------- result side ----------------

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h (cycle %0d)", field, want, got, cycle_count);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(RX_ALWAYS, RX_SPARSE);
            stall_timer <= $urandom_range(20, 120);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            RX_ALWAYS:   m_ready <= 1'b1;
            RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_ready <= (cycle_count % 5 == 0);
            default:     m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin : check_digest
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest word", 32'h0, m_data.digest_word);
            end else begin
                want = digest_q.pop_front();
                if (m_data.digest_word !== want.digest_word)
                    report_mismatch("digest_word", want.digest_word, m_data.digest_word);
                if (m_data.word_index !== want.word_index)
                    report_mismatch("word_index", 32'(want.word_index), 32'(m_data.word_index));
                if (m_data.last_result !== want.last_result)
                    report_mismatch("last_result", 32'(want.last_result),
                                    32'(m_data.last_result));
            end
        end
    end

    // ---------------- input side ----------------

    function automatic logic [31:0] pick_data();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 32'h0;
        if (sel == 1) return 32'hffff_ffff;
        return $urandom();
    endfunction

    // Entered and left just after a rising edge; returns at the accepting edge.
    task automatic send_word(logic [31:0] data, logic [2:0] nbytes, logic fin);
        in_word_t    item;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        item.data_word   = data;
        item.valid_bytes = nbytes;
        item.last_word   = fin;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_word(data, nbytes, fin);
    endtask

    task automatic send_message(int unsigned body_words, logic [2:0] tail_bytes);
        for (int unsigned i = 0; i < body_words; i++)
            send_word(pick_data(), 3'($urandom_range(0, 7)), 1'b0);
        send_word(pick_data(), tail_bytes, 1'b1);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
    endtask

    // ---------------- tests ----------------

    // One-word messages: empty, partial last words with set bits to mask, a full last
    // word, and byte counts above four that must saturate.
    task automatic test_short_last_words();
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b1);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'h6162_6380, 3'd5, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
    endtask

    // Full last word at slot 14: pad word lands in slot 15, length needs a second block.
    task automatic test_two_block_pad();
        for (int i = 0; i < 14; i++)
            send_word((i % 2 == 0) ? 32'h0 : 32'hffff_ffff, 3'($urandom_range(0, 7)), 1'b0);
        send_word(32'h8000_0001, 3'd4, 1'b1);
    endtask

    task automatic test_random_messages();
        int unsigned sent;
        int unsigned body;
        logic [2:0]  tail;
        bit          paused;
        sent   = 0;
        paused = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 3))
                0:       body = $urandom_range(0, 3);
                // last word near the block end: one or two pad blocks
                1:       body = $urandom_range(12, 15) + 16 * $urandom_range(0, 1);
                default: body = $urandom_range(0, 40);
            endcase
            tail = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_message(body, tail);
            sent += body + 1;
            if (!paused && sent >= RANDOM_WORDS / 2) begin
                wait_for_drain();
                paused = 1;
            end
        end
    endtask

    initial begin
        restart_hash();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_last_words();
        test_two_block_pad();
        test_random_messages();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
